### rtl/ccpc_pkg.sv
// ----------------------------------------------------------------------------
// ccpc_pkg
// Shared widths and defaults for the cyclic cover pair checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpc_pkg;

  // width of each word field on the channels
  localparam int FIELD_BITS = 13;

  // default ring width of the rotation test
  localparam int WORD_BITS_DEFAULT = 13;

  // limits of the ring width
  localparam int WORD_BITS_MIN = 2;
  localparam int WORD_BITS_MAX = 32;

endpackage : ccpc_pkg

`default_nettype wire

### rtl/ccpc_pair_if.sv
// ----------------------------------------------------------------------------
// ccpc_pair_if
// Candidate pair channel: valid/ready handshake with both words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccpc_pair_if;
  import ccpc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] first_word;
  logic [FIELD_BITS-1:0] second_word;

  modport source (output valid, output first_word, output second_word, input ready);
  modport sink   (input valid, input first_word, input second_word, output ready);

endinterface : ccpc_pair_if

`default_nettype wire

### rtl/ccpc_result_if.sv
// ----------------------------------------------------------------------------
// ccpc_result_if
// Result channel: valid/ready handshake with the verdict and echoed pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccpc_result_if;
  import ccpc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  qualifies;
  logic [FIELD_BITS-1:0] first_echo;
  logic [FIELD_BITS-1:0] second_echo;

  modport source (output valid, output qualifies, output first_echo, output second_echo,
                  input ready);
  modport sink   (input valid, input qualifies, input first_echo, input second_echo,
                  output ready);

endinterface : ccpc_result_if

`default_nettype wire

### rtl/ccpc_word_check.sv
// ----------------------------------------------------------------------------
// ccpc_word_check
// Rotation containment test of one word against the union and the other word.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpc_word_check #(
  parameter int WORD_BITS = ccpc_pkg::WORD_BITS_DEFAULT
) (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [WORD_BITS-1:0] other,
  output logic                      passes
);
  import ccpc_pkg::*;

  logic [WORD_BITS-1:0]   union_word;
  logic [2*WORD_BITS-1:0] union_dbl;
  logic [2*WORD_BITS-1:0] other_dbl;
  logic [WORD_BITS-1:0]   in_union;
  logic [WORD_BITS-1:0]   in_other;

  // doubled copies give every rotation as a constant part-select
  assign union_word = word | other;
  assign union_dbl  = {union_word, union_word};
  assign other_dbl  = {other, other};

  // one containment test per rotation amount
  for (genvar s = 0; s < WORD_BITS; s++) begin : g_rot
    assign in_union[s] = ~|(word & ~union_dbl[s +: WORD_BITS]);
    assign in_other[s] = ~|(word & ~other_dbl[s +: WORD_BITS]);
  end

  // covered by the union only unrotated, never by the other word
  assign passes = in_union[0] & ~|in_union[WORD_BITS-1:1] & ~|in_other;

endmodule : ccpc_word_check

`default_nettype wire

### rtl/cyclic_cover_pair_checker_core.sv
// The result register loads from the input register after a candidate transfer,
// so a verdict passes through both registers before it can be transferred.
// Throughput: one pair per cycle while each verdict is taken; the rotation
// test is a single pass between the input register and the result register.
// The input stalls only when both registers are full and the result is not taken.
// Reset (synchronous, rst high) empties both stages; data is not reset.
// ----------------------------------------------------------------------------
// cyclic_cover_pair_checker_core
// Two-stage pair checker: input register, rotation test, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_cover_pair_checker_core #(
  parameter int WORD_BITS = ccpc_pkg::WORD_BITS_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ccpc_pair_if.sink   candidate,
  ccpc_result_if.source verdict
);
  import ccpc_pkg::*;

  logic                  in_valid;
  logic [FIELD_BITS-1:0] in_first;
  logic [FIELD_BITS-1:0] in_second;
  logic                  in_ready;
  logic                  res_ready;

  logic [WORD_BITS-1:0]  first_ring;
  logic [WORD_BITS-1:0]  second_ring;
  logic                  first_pass;
  logic                  second_pass;

  logic                  res_valid;
  logic                  res_qualifies;
  logic [FIELD_BITS-1:0] res_first;
  logic [FIELD_BITS-1:0] res_second;

  // stage readiness: a stage takes data when empty or draining
  assign res_ready       = ~res_valid | verdict.ready;
  assign in_ready        = ~in_valid | res_ready;
  assign candidate.ready = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= candidate.valid;
    end
    if (in_ready && candidate.valid) begin
      in_first  <= candidate.first_word;
      in_second <= candidate.second_word;
    end
  end

  // fit the fields to the ring width, dropping or zero-filling upper bits
  for (genvar i = 0; i < WORD_BITS; i++) begin : g_ring
    if (i < FIELD_BITS) begin : g_bit
      assign first_ring[i]  = in_first[i];
      assign second_ring[i] = in_second[i];
    end else begin : g_zero
      assign first_ring[i]  = 1'b0;
      assign second_ring[i] = 1'b0;
    end
  end

  // each word tested against the other
  ccpc_word_check #(.WORD_BITS(WORD_BITS)) u_first_check (
    .word   (first_ring),
    .other  (second_ring),
    .passes (first_pass)
  );

  ccpc_word_check #(.WORD_BITS(WORD_BITS)) u_second_check (
    .word   (second_ring),
    .other  (first_ring),
    .passes (second_pass)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= in_valid;
    end
    if (res_ready && in_valid) begin
      res_qualifies <= first_pass & second_pass;
      res_first     <= in_first;
      res_second    <= in_second;
    end
  end

  assign verdict.valid       = res_valid;
  assign verdict.qualifies   = res_qualifies;
  assign verdict.first_echo  = res_first;
  assign verdict.second_echo = res_second;

endmodule : cyclic_cover_pair_checker_core

`default_nettype wire

### rtl/ccpc_checker.sv
// ----------------------------------------------------------------------------
// ccpc_checker
// Port-level checks of the pair checker, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            qualifies,
  input wire logic [ccpc_pkg::FIELD_BITS-1:0] first_echo,
  input wire logic [ccpc_pkg::FIELD_BITS-1:0] second_echo
);
  import ccpc_pkg::*;

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(qualifies) &&
      $stable(first_echo) && $stable(second_echo))
    else $error("stalled result changed");

  // equal or zero words never qualify
  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    out_valid && qualifies |-> first_echo != second_echo &&
      first_echo != '0 && second_echo != '0)
    else $error("equal or zero word reported as qualifying");

  // a qualifying word is never covered by the other word unrotated
  a_not_subset: assert property (@(posedge clk) disable iff (rst)
    out_valid && qualifies |->
      (first_echo & ~second_echo) != '0 && (second_echo & ~first_echo) != '0)
    else $error("qualifying word contained in its partner");

endmodule : ccpc_checker

bind cyclic_cover_pair_checker_core ccpc_checker u_ccpc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (verdict.valid),
  .out_ready   (verdict.ready),
  .qualifies   (verdict.qualifies),
  .first_echo  (verdict.first_echo),
  .second_echo (verdict.second_echo)
);

`default_nettype wire
